>>> src/sps_pkg.sv
// Shared types and constants of the streaming prime sieve.
package sps_pkg;

  localparam int unsigned FIELD_WIDTH = 16;
  localparam int unsigned MAX_PRIMES  = 16;
  localparam int unsigned VALUE_WIDTH = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [FIELD_WIDTH-1:0] value;
    logic                   end_of_stream;
  } sps_in_t;

  typedef struct packed {
    logic [FIELD_WIDTH-1:0] prime;
    logic                   overflow;
  } sps_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_START,
    ST_DIV,
    ST_EMIT
  } sps_state_e;

endpackage

>>> src/sps_fifo.sv
// Small synchronous queue with push/full and pop/empty sides.
module sps_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = sps_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> src/sps_front.sv
// Front end: masks and classifies incoming requests, queues the useful ones.
module sps_front #(
  parameter int unsigned VALUE_WIDTH = sps_pkg::VALUE_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  sps_pkg::sps_in_t       item_i,
  output logic                   cmd_valid_o,
  input  logic                   cmd_pop_i,
  output logic                   cmd_eos_o,
  output logic [VALUE_WIDTH-1:0] cmd_value_o
);

  logic [VALUE_WIDTH-1:0] value;
  logic                   keep;
  logic                   cmd_empty;

  // Value taken modulo 2^VALUE_WIDTH, zero-extended when wider than the field.
  always_comb begin
    for (int i = 0; i < int'(VALUE_WIDTH); i++) begin
      value[i] = (i < int'(sps_pkg::FIELD_WIDTH)) ? item_i.value[i] : 1'b0;
    end
  end

  // Candidates below two are swallowed here.
  assign keep = item_i.end_of_stream || (value > VALUE_WIDTH'(1));

  sps_fifo #(
    .WIDTH (VALUE_WIDTH + 1),
    .DEPTH (sps_pkg::QUEUE_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && keep),
    .data_i  ({item_i.end_of_stream, value}),
    .full_o  (full),
    .pop_i   (cmd_pop_i),
    .data_o  ({cmd_eos_o, cmd_value_o}),
    .empty_o (cmd_empty)
  );

  assign cmd_valid_o = !cmd_empty;

endmodule

>>> src/sps_rem.sv
// Iterative restoring remainder unit, one quotient bit per cycle.
module sps_rem #(
  parameter int unsigned VALUE_WIDTH = sps_pkg::VALUE_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [VALUE_WIDTH-1:0] divisor_i,
  output logic                   done_o,
  output logic                   zero_o
);

  localparam int unsigned NW = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] rem_q, dvd_q, dsr_q;
  logic [NW-1:0]          cnt_q;
  logic                   busy_q, done_q;
  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   diff;
  logic                   ge;

  assign trial = {rem_q, dvd_q[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = (trial >= {1'b0, dsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == NW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= NW'(VALUE_WIDTH);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == NW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // remainder stays below the divisor, so the low VALUE_WIDTH bits suffice
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
      dvd_q <= {dvd_q[VALUE_WIDTH-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign zero_o = (rem_q == '0);

endmodule

>>> src/sps_back.sv
// Back end: walks the stored primes through the remainder unit, emits survivors.
module sps_back #(
  parameter int unsigned MAX_PRIMES  = sps_pkg::MAX_PRIMES,
  parameter int unsigned VALUE_WIDTH = sps_pkg::VALUE_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cmd_valid_i,
  output logic                   cmd_pop_o,
  input  logic                   cmd_eos_i,
  input  logic [VALUE_WIDTH-1:0] cmd_value_i,
  output logic                   res_push_o,
  input  logic                   res_full_i,
  output sps_pkg::sps_out_t      res_o
);

  localparam int unsigned IW = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
  localparam int unsigned CW = $clog2(MAX_PRIMES + 1);

  sps_pkg::sps_state_e state_q, state_d;

  logic [VALUE_WIDTH-1:0] mem [MAX_PRIMES];
  logic [VALUE_WIDTH-1:0] rd_q;
  logic [VALUE_WIDTH-1:0] v_q;
  logic [CW-1:0]          count_q;
  logic [CW-1:0]          idx_q;
  logic [CW-1:0]          idx_inc;
  logic                   list_full;
  logic                   div_start, div_done, div_zero;
  logic                   mem_we;

  assign idx_inc   = idx_q + 1'b1;
  assign list_full = (count_q == CW'(MAX_PRIMES));

  sps_rem #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (v_q),
    .divisor_i  (rd_q),
    .done_o     (div_done),
    .zero_o     (div_zero)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sps_pkg::ST_IDLE: begin
        if (cmd_valid_i && !cmd_eos_i) begin
          state_d = (count_q == '0) ? sps_pkg::ST_EMIT : sps_pkg::ST_FETCH;
        end
      end
      sps_pkg::ST_FETCH: state_d = sps_pkg::ST_START;
      sps_pkg::ST_START: state_d = sps_pkg::ST_DIV;
      sps_pkg::ST_DIV: begin
        if (div_done) begin
          if (div_zero) begin
            state_d = sps_pkg::ST_IDLE;
          end else if (idx_inc == count_q) begin
            state_d = sps_pkg::ST_EMIT;
          end else begin
            state_d = sps_pkg::ST_FETCH;
          end
        end
      end
      sps_pkg::ST_EMIT: begin
        if (!res_full_i) begin
          state_d = sps_pkg::ST_IDLE;
        end
      end
      default: state_d = sps_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_pop_o  = 1'b0;
    div_start  = 1'b0;
    res_push_o = 1'b0;
    unique case (state_q)
      sps_pkg::ST_IDLE:  cmd_pop_o  = cmd_valid_i;
      sps_pkg::ST_START: div_start  = 1'b1;
      sps_pkg::ST_EMIT:  res_push_o = !res_full_i;
      default: ;
    endcase
  end

  assign mem_we = res_push_o && !list_full;

  always_comb begin
    res_o.overflow = list_full;
    for (int i = 0; i < int'(sps_pkg::FIELD_WIDTH); i++) begin
      res_o.prime[i] = (i < int'(VALUE_WIDTH)) ? v_q[i] : 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sps_pkg::ST_IDLE;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cmd_pop_o) begin
        idx_q <= '0;
        if (cmd_eos_i) begin
          count_q <= '0;
        end
      end else if (state_q == sps_pkg::ST_DIV && div_done && !div_zero) begin
        idx_q <= idx_inc;
      end
      if (mem_we) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      v_q <= cmd_value_i;
    end
  end

  // prime list
  always_ff @(posedge clk_i) begin
    rd_q <= mem[idx_q[IW-1:0]];
    if (mem_we) begin
      mem[count_q[IW-1:0]] <= v_q;
    end
  end

endmodule

>>> src/streaming_prime_sieve_core.sv
// Streaming prime sieve: top level with front queue, sieve engine and result queue.
//
// Usage: candidates enter on item_i with push/full; a request is taken when
// push is high and full is low. Results leave on result_o with empty/pop; the
// oldest result is shown while empty is low and retires on pop.
// Each candidate (masked to VALUE_WIDTH bits) is divided by the stored
// primes in turn, up to the first one that divides it. A survivor is
// emitted and appended to the list; with the list full it is emitted with
// overflow set. Candidates below two are dropped on entry, an end_of_stream
// request empties the list and produces no result.
// The engine takes a request, tries the stored primes one after another
// (fetch, load, VALUE_WIDTH remainder steps, done) and emits a survivor;
// the single remainder unit sets the pace, and a new request is taken only
// once the last one is through. An end of stream is done when taken.
// A request passes through the input queue to the engine; a survivor passes
// through the result queue to result_o.
// Reset empties both queues and the prime list; list storage is not cleared.
// A stalled receiver fills the two-entry result queue, then the engine
// waits, then the two-entry input queue fills and full rises.
module streaming_prime_sieve_core #(
  parameter int unsigned MAX_PRIMES  = sps_pkg::MAX_PRIMES,
  parameter int unsigned VALUE_WIDTH = sps_pkg::VALUE_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  sps_pkg::sps_in_t  item_i,
  output logic              empty,
  input  logic              pop,
  output sps_pkg::sps_out_t result_o
);

  logic                   cmd_valid, cmd_pop, cmd_eos;
  logic [VALUE_WIDTH-1:0] cmd_value;
  logic                   res_push, res_full;
  sps_pkg::sps_out_t      res;

  sps_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_eos_o   (cmd_eos),
    .cmd_value_o (cmd_value)
  );

  sps_back #(
    .MAX_PRIMES  (MAX_PRIMES),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_eos_i   (cmd_eos),
    .cmd_value_i (cmd_value),
    .res_push_o  (res_push),
    .res_full_i  (res_full),
    .res_o       (res)
  );

  // result queue decouples the engine from a stalling receiver
  sps_fifo #(
    .WIDTH ($bits(sps_pkg::sps_out_t)),
    .DEPTH (sps_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (result_o),
    .empty_o (empty)
  );

  // engine never pushes a result into a full queue
  a_res_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  // engine only takes a request that is present
  a_cmd_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("request taken from empty queue");

  // every emitted prime is at least two
  a_prime_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (result_o.prime > 16'd1))
    else $error("emitted value below two");

  // a result push never coincides with taking a new request
  a_engine_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_push && cmd_pop))
    else $error("engine overlap between request and result");

endmodule

>>> test/tb_streaming_prime_sieve_core.sv
// Self-checking testbench for streaming_prime_sieve_core: directed and random candidate streams.
module tb_streaming_prime_sieve_core;

  localparam int unsigned MAX_PRIMES  = sps_pkg::MAX_PRIMES;
  localparam int unsigned VALUE_WIDTH = sps_pkg::VALUE_WIDTH;

  // Longest engine time for one request: take and emit plus a full remainder pass
  // over every stored prime. The end of the run waits well past this so that
  // dropped candidates still in flight can show up as stray results.
  localparam int unsigned ENGINE_WORST = 2 + MAX_PRIMES * (VALUE_WIDTH + 3);
  localparam int unsigned SETTLE_CYCLES = 4 * ENGINE_WORST + 20;
  localparam int unsigned RANDOM_ITEMS = 575;

  logic              clk_i;
  logic              rst_ni;
  logic              push;
  logic              full;
  sps_pkg::sps_in_t  sieve_req;
  logic              empty;
  logic              pop;
  sps_pkg::sps_out_t sieve_rsp;

  streaming_prime_sieve_core u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .item_i  (sieve_req),
    .empty   (empty),
    .pop     (pop),
    .result_o(sieve_rsp)
  );

  // Shadow copy of the prime list, kept in step with every accepted request.
  logic [VALUE_WIDTH-1:0] primes_held [MAX_PRIMES];
  int unsigned            primes_held_cnt;

  // Primes the block still owes us, oldest first.
  sps_pkg::sps_out_t primes_due [$];
  sps_pkg::sps_out_t due_head;

  int unsigned fail_count;
  int unsigned n_counted;   // accepted requests that are not silently ignored
  int unsigned n_eos;
  int unsigned n_results;
  int unsigned n_overflow;

  // When set, that side runs back to back with no idle cycles.
  bit tx_steady;
  bit rx_steady;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or loses results.
  initial begin
    #3000000;
    $display("timeout: %0d primes still outstanding", primes_due.size());
    $display("*** FAILED ***");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap(input bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input logic [VALUE_WIDTH-1:0] got,
                                 input logic [VALUE_WIDTH-1:0] want);
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // Sieve step on the shadow state: clears on end of stream, skips values
  // below two, drops anything a held prime divides, and otherwise queues the
  // prime, storing it if the list still has room.
  task automatic sieve_update(input sps_pkg::sps_in_t req);
    logic [VALUE_WIDTH-1:0] cand;
    sps_pkg::sps_out_t      res;
    cand = req.value[VALUE_WIDTH-1:0];
    if (req.end_of_stream) begin
      primes_held_cnt = 0;
      n_eos++;
      n_counted++;
      return;
    end
    if (cand < 2) return;
    n_counted++;
    for (int unsigned i = 0; i < primes_held_cnt; i++) begin
      if (cand % primes_held[i] == 0) return;
    end
    res.prime = cand;
    if (primes_held_cnt < MAX_PRIMES) begin
      primes_held[primes_held_cnt] = cand;
      primes_held_cnt++;
      res.overflow = 1'b0;
    end else begin
      res.overflow = 1'b1;
    end
    primes_due.push_back(res);
  endtask

  // Drive one request at a falling edge and hold it until the rising edge
  // that takes it. push stays high afterwards; the next caller either puts
  // a new request on it or lowers it.
  task automatic send_request(input sps_pkg::sps_in_t req);
    int unsigned gap;
    gap = pick_gap(tx_steady);
    @(negedge clk_i);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push      <= 1'b1;
    sieve_req <= req;
    do @(posedge clk_i); while (full);
    sieve_update(req);
  endtask

  task automatic send_value(input logic [VALUE_WIDTH-1:0] v);
    sps_pkg::sps_in_t req;
    req.value         = v;
    req.end_of_stream = 1'b0;
    send_request(req);
  endtask

  task automatic send_eos(input logic [VALUE_WIDTH-1:0] v);
    sps_pkg::sps_in_t req;
    req.value         = v;
    req.end_of_stream = 1'b1;
    send_request(req);
  endtask

  // Sender goes quiet until every owed prime has been popped.
  task automatic pause_until_drained();
    @(negedge clk_i);
    push <= 1'b0;
    while (primes_due.size() != 0) @(posedge clk_i);
  endtask

  // Values 0 and 1 are skipped, a repeat of a held prime is dropped, and a
  // multiple of a held prime is dropped.
  task automatic test_ignored_and_repeat();
    send_value(0);
    send_value(1);
    send_value(2);
    send_value(2);
    send_value(4);
    send_value(3);
  endtask

  // Fill the list to its last slot with the next primes, then check that
  // further survivors carry the overflow flag, up to the largest 16-bit prime.
  task automatic test_list_fill_overflow();
    int unsigned fill [14] = '{5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53};
    foreach (fill[i]) send_value(VALUE_WIDTH'(fill[i]));
    send_value(59);
    send_value(65521);
  endtask

  // Terminator with an all-ones value, then the top of the value range.
  // 65535 is composite but nothing held divides it, so it survives.
  task automatic test_top_values();
    send_eos('1);
    send_value(65521);
    send_value(65535);
    send_value(65535);
    send_eos('0);
  endtask

  task automatic test_drain_pause();
    send_eos(VALUE_WIDTH'($urandom_range(0, 65535)));
    for (int unsigned v = 2; v < 12; v++) send_value(VALUE_WIDTH'(v));
    pause_until_drained();
  endtask

  // A clean run: terminator, then a stretch of consecutive candidates with
  // an occasional random one mixed in. Starting at 2 this is the textbook
  // sieve and fills the list by 53; starting high every value survives and
  // the list fills at once.
  task automatic sieve_run(input bit with_eos);
    int unsigned start, len;
    logic [VALUE_WIDTH-1:0] v;
    if (with_eos) send_eos(VALUE_WIDTH'($urandom_range(0, 65535)));
    start = ($urandom_range(0, 2) != 0) ? 2 : $urandom_range(2, 65400);
    len   = $urandom_range(4, 70);
    for (int unsigned k = 0; k < len; k++) begin
      v = VALUE_WIDTH'(start + k);
      if ($urandom_range(0, 9) == 0) v = VALUE_WIDTH'($urandom_range(0, 65535));
      if (!with_eos && $urandom_range(0, 29) == 0)
        send_eos(VALUE_WIDTH'($urandom_range(0, 65535)));
      send_value(v);
    end
  endtask

  task automatic noise_burst();
    int unsigned len, r;
    len = $urandom_range(5, 20);
    repeat (len) begin
      r = $urandom_range(0, 19);
      if (r == 0) send_eos(VALUE_WIDTH'($urandom_range(0, 65535)));
      else if (r == 1) send_value(VALUE_WIDTH'($urandom_range(0, 1)));
      else send_value(VALUE_WIDTH'($urandom_range(0, 65535)));
    end
  endtask

  // Mostly well-formed sieve runs; some noise, some runs that pick up a stale
  // list or lose it midway, and now and then a full drain.
  task automatic test_random_streams();
    int unsigned kind, goal;
    goal = n_counted + RANDOM_ITEMS;
    while (n_counted < goal) begin
      tx_steady = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 9);
      if (kind <= 5) sieve_run(1'b1);
      else if (kind <= 7) noise_burst();
      else if (kind == 8) sieve_run(1'b0);
      else pause_until_drained();
    end
    tx_steady = 1'b0;
  endtask

  // Receiver: alternating stalls and pop bursts, with steady stretches.
  initial begin : drain_side
    int unsigned stall, run;
    pop       = 1'b0;
    rx_steady = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 19) == 0) rx_steady = ~rx_steady;
      stall = pick_gap(rx_steady);
      run   = $urandom_range(1, 12);
      repeat (stall) begin
        @(negedge clk_i);
        pop <= 1'b0;
      end
      repeat (run) begin
        @(negedge clk_i);
        pop <= 1'b1;
      end
    end
  end

  // Every popped result must match the oldest owed prime.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      n_results++;
      if (primes_due.size() == 0) begin
        report_mismatch("prime with none owed", sieve_rsp.prime, '0);
      end else begin
        due_head = primes_due.pop_front();
        if (due_head.overflow) n_overflow++;
        if (sieve_rsp.prime !== due_head.prime)
          report_mismatch("prime", sieve_rsp.prime, due_head.prime);
        if (sieve_rsp.overflow !== due_head.overflow)
          report_mismatch("overflow", sieve_rsp.overflow, due_head.overflow);
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    push            = 1'b0;
    sieve_req       = '0;
    primes_held_cnt = 0;
    fail_count      = 0;
    n_counted       = 0;
    n_eos           = 0;
    n_results       = 0;
    n_overflow      = 0;
    tx_steady       = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_ignored_and_repeat();
    test_list_fill_overflow();
    test_top_values();
    test_drain_pause();
    test_random_streams();

    // Everything owed must arrive, then give the engine time to show strays.
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Streamed %0d candidates and terminators (%0d end-of-stream markers).",
             n_counted, n_eos);
    $display("Checked %0d primes, %0d of them flagged with the list full.",
             n_results, n_overflow);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> streaming_prime_sieve_core.f
src/sps_pkg.sv
src/sps_fifo.sv
src/sps_front.sv
src/sps_rem.sv
src/sps_back.sv
src/streaming_prime_sieve_core.sv
test/tb_streaming_prime_sieve_core.sv
